FILE: rtl/rru_pkg.sv
// Shared constants, status types and rounding helper for the refract/reflect unit.
package rru_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int FIFO_DEPTH     = 4;
    localparam int RND_W          = 128;

    localparam logic MODE_REFLECT = 1'b0;
    localparam logic MODE_REFRACT = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } fq_status_t;

    // Divide by 2^f, round to nearest, ties toward plus infinity.
    function automatic logic signed [RND_W-1:0] rnd_q(
        input logic signed [RND_W-1:0] x,
        input int unsigned             f
    );
        logic signed [RND_W-1:0] half;
        half = 128'sd1 <<< (f - 1);
        return (x + half) >>> f;
    endfunction

endpackage

FILE: rtl/rru_front.sv
// Front end: accept ray hits, form the clamped dot product I.N.
module rru_front #(
    parameter int W = rru_pkg::COMP_WIDTH_DEF,
    parameter int F = rru_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_mode,
    input  logic signed [W-1:0] in_inc [3],
    input  logic signed [W-1:0] in_nrm [3],
    input  logic [W-1:0]        in_eta,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_mode,
    output logic signed [F+1:0] out_d,
    output logic signed [W-1:0] out_inc [3],
    output logic signed [W-1:0] out_nrm [3],
    output logic [W-1:0]        out_eta
);
    localparam int XW = rru_pkg::RND_W;
    localparam int DW = F + 2;
    localparam int OW = ((2 * W > F) ? 2 * W : F) + 4;
    localparam logic signed [OW-1:0] ONE_O = OW'(64'sd1 <<< F);

    logic                  v1_reg, v2_reg;
    logic signed [2*W-1:0] prod1_reg [3];
    logic signed [W-1:0]   inc1_reg [3], nrm1_reg [3];
    logic [W-1:0]          eta1_reg;
    logic                  mode1_reg;
    logic signed [DW-1:0]  d2_reg, d2_next;
    logic signed [W-1:0]   inc2_reg [3], nrm2_reg [3];
    logic [W-1:0]          eta2_reg;
    logic                  mode2_reg;
    logic signed [OW-1:0]  sum;
    logic                  adv;

    assign adv      = !v2_reg || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        sum = OW'(rru_pkg::rnd_q(XW'(prod1_reg[0]), F))
            + OW'(rru_pkg::rnd_q(XW'(prod1_reg[1]), F))
            + OW'(rru_pkg::rnd_q(XW'(prod1_reg[2]), F));
        if (sum > ONE_O)
            d2_next = DW'(ONE_O);
        else if (sum < -ONE_O)
            d2_next = DW'(-ONE_O);
        else
            d2_next = DW'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod1_reg[i] <= in_inc[i] * in_nrm[i];
                inc1_reg[i]  <= in_inc[i];
                nrm1_reg[i]  <= in_nrm[i];
                inc2_reg[i]  <= inc1_reg[i];
                nrm2_reg[i]  <= nrm1_reg[i];
            end
            eta1_reg  <= in_eta;
            mode1_reg <= in_mode;
            d2_reg    <= d2_next;
            eta2_reg  <= eta1_reg;
            mode2_reg <= mode1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_mode  = mode2_reg;
    assign out_d     = d2_reg;
    assign out_eta   = eta2_reg;
    assign out_inc   = inc2_reg;
    assign out_nrm   = nrm2_reg;
endmodule

FILE: rtl/rru_fifo.sv
// Short word queue between the front and back ends.
module rru_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rru_pkg::FIFO_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [WIDTH-1:0]       in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [WIDTH-1:0]       out_data,
    output rru_pkg::fq_status_t    status
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [CW-1:0]    cnt_reg;
    logic             push, pop;

    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign in_ready     = !status.full;
    assign out_valid    = !status.empty;
    assign push         = in_valid && !status.full;
    assign pop          = out_valid && out_ready;
    assign out_data     = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_data;
    end
endmodule

FILE: rtl/rru_back.sv
// Back end: refraction term, pipelined square root, result select and saturation.
module rru_back #(
    parameter int W = rru_pkg::COMP_WIDTH_DEF,
    parameter int F = rru_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_mode,
    input  logic signed [F+1:0] in_d,
    input  logic signed [W-1:0] in_inc [3],
    input  logic signed [W-1:0] in_nrm [3],
    input  logic [W-1:0]        in_eta,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [W-1:0] out_comp [3],
    output logic                out_tir,
    output logic                out_clip
);
    localparam int XW  = rru_pkg::RND_W;
    localparam int R   = F + 1;
    localparam int DW  = F + 2;
    localparam int EW  = W + 1;
    localparam int TW  = F + 2;
    localparam int UW  = W + 2;
    localparam int KW  = ((2 * W > F) ? 2 * W : F) + 4;
    localparam int EEW = W + 3;
    localparam int OW  = ((2 * W > F) ? 2 * W : F) + 4;
    localparam int CN  = 3 + R;
    localparam logic signed [TW-1:0] ONE_T = TW'(64'sd1 <<< F);
    localparam logic signed [KW-1:0] ONE_K = KW'(64'sd1 <<< F);
    localparam logic signed [OW-1:0] HI_O  = OW'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [OW-1:0] LO_O  = -HI_O - OW'(1);

    logic en;

    // first stage: products of d
    logic                     v0_reg;
    logic signed [2*DW-1:0]   dd0_reg;
    logic signed [DW+W-1:0]   dn0_reg [3];
    logic signed [EW+W-1:0]   ei0_reg [3];
    logic signed [EW+DW-1:0]  ed0_reg;
    logic signed [W-1:0]      inc0_reg [3], nrm0_reg [3];
    logic signed [EW-1:0]     eta0_reg, eta_in;
    logic                     mode0_reg;

    // eta^2 chain
    logic signed [TW-1:0]     t1;
    logic signed [EW+TW-1:0]  etat1_reg;
    logic signed [EW-1:0]     eta1_reg;
    logic                     mode1_reg, mode2_reg;
    logic signed [UW-1:0]     u2;
    logic signed [EW+UW-1:0]  etau2_reg;
    logic signed [KW-1:0]     k3;

    // carried through the root stages
    logic                     vc_reg   [CN];
    logic signed [OW-1:0]     refl_reg [CN][3];
    logic signed [OW-1:0]     ai_reg   [CN][3];
    logic signed [EEW-1:0]    e_reg    [CN];
    logic signed [W-1:0]      nrm_reg  [CN][3];

    // root stages, index 0 loaded with k
    logic [2*R-1:0]           rad_reg  [R+1];
    logic [R+1:0]             rem_reg  [R+1];
    logic [R-1:0]             root_reg [R+1];
    logic                     tir_reg  [R+1];
    logic                     usr_reg  [R+1];

    // products and output
    logic                     vp_reg, vo_reg;
    logic signed [R+W:0]      sn_reg [3];
    logic signed [EEW+W-1:0]  en_reg [3];
    logic signed [OW-1:0]     reflp_reg [3], aip_reg [3];
    logic                     tirp_reg, usrp_reg;
    logic signed [OW-1:0]     res [3];
    logic signed [W-1:0]      comp_next [3];
    logic                     clip_next;
    logic signed [W-1:0]      comp_reg [3];
    logic                     tir_o_reg, clip_o_reg;

    assign en       = !vo_reg || out_ready;
    assign in_ready = en;
    assign eta_in   = $signed({1'b0, in_eta});

    assign t1 = ONE_T - TW'(rru_pkg::rnd_q(XW'(dd0_reg), F));
    assign u2 = UW'(rru_pkg::rnd_q(XW'(etat1_reg), F));
    assign k3 = ONE_K - KW'(rru_pkg::rnd_q(XW'(etau2_reg), F));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            for (int c = 0; c < CN; c++)
                vc_reg[c] <= 1'b0;
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_valid;
            vc_reg[0] <= v0_reg;
            for (int c = 1; c < CN; c++)
                vc_reg[c] <= vc_reg[c-1];
            vp_reg <= vc_reg[CN-1];
            vo_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 0
            dd0_reg   <= in_d * in_d;
            ed0_reg   <= eta_in * in_d;
            eta0_reg  <= eta_in;
            mode0_reg <= in_mode;
            for (int i = 0; i < 3; i++)
            begin
                dn0_reg[i]  <= in_d * in_nrm[i];
                ei0_reg[i]  <= eta_in * in_inc[i];
                inc0_reg[i] <= in_inc[i];
                nrm0_reg[i] <= in_nrm[i];
            end
            // stage 1: t, reflection, eta*I and eta*d rounded
            etat1_reg <= eta0_reg * t1;
            eta1_reg  <= eta0_reg;
            mode1_reg <= mode0_reg;
            e_reg[0]  <= EEW'(rru_pkg::rnd_q(XW'(ed0_reg), F));
            for (int i = 0; i < 3; i++)
            begin
                refl_reg[0][i] <= OW'(inc0_reg[i])
                                - OW'(rru_pkg::rnd_q(XW'(dn0_reg[i]) <<< 1, F));
                ai_reg[0][i]   <= OW'(rru_pkg::rnd_q(XW'(ei0_reg[i]), F));
                nrm_reg[0][i]  <= nrm0_reg[i];
            end
            // stage 2: eta*u
            etau2_reg <= eta1_reg * u2;
            mode2_reg <= mode1_reg;
            // stage 3: k, fallback decision, root seed
            tir_reg[0]  <= (mode2_reg == rru_pkg::MODE_REFRACT) && k3[KW-1];
            usr_reg[0]  <= (mode2_reg == rru_pkg::MODE_REFLECT) || k3[KW-1];
            rad_reg[0]  <= k3[KW-1] ? '0 : (2*R)'({k3[F:0], {F{1'b0}}});
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            // carry
            for (int c = 1; c < CN; c++)
            begin
                e_reg[c] <= e_reg[c-1];
                for (int i = 0; i < 3; i++)
                begin
                    refl_reg[c][i] <= refl_reg[c-1][i];
                    ai_reg[c][i]   <= ai_reg[c-1][i];
                    nrm_reg[c][i]  <= nrm_reg[c-1][i];
                end
            end
            // products with root and e
            for (int i = 0; i < 3; i++)
            begin
                sn_reg[i]    <= $signed({1'b0, root_reg[R]}) * nrm_reg[CN-1][i];
                en_reg[i]    <= e_reg[CN-1] * nrm_reg[CN-1][i];
                reflp_reg[i] <= refl_reg[CN-1][i];
                aip_reg[i]   <= ai_reg[CN-1][i];
            end
            tirp_reg <= tir_reg[R];
            usrp_reg <= usr_reg[R];
            // output
            comp_reg   <= comp_next;
            tir_o_reg  <= tirp_reg;
            clip_o_reg <= clip_next;
        end
    end

    // one root bit per stage
    for (genvar j = 0; j < R; j++)
    begin : g_root
        logic [R+3:0] remsh, trial;
        assign remsh = {rem_reg[j], rad_reg[j][2*R-1 -: 2]};
        assign trial = (R+4)'({root_reg[j], 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[j+1] <= rad_reg[j] << 2;
                tir_reg[j+1] <= tir_reg[j];
                usr_reg[j+1] <= usr_reg[j];
                if (remsh >= trial)
                begin
                    rem_reg[j+1]  <= (R+2)'(remsh - trial);
                    root_reg[j+1] <= {root_reg[j][R-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j+1]  <= (R+2)'(remsh);
                    root_reg[j+1] <= {root_reg[j][R-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        clip_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (usrp_reg)
                res[i] = reflp_reg[i];
            else
                res[i] = aip_reg[i]
                       - OW'(rru_pkg::rnd_q(XW'(sn_reg[i]), F))
                       - OW'(rru_pkg::rnd_q(XW'(en_reg[i]), F));
            if (res[i] > HI_O)
            begin
                comp_next[i] = W'(HI_O);
                clip_next    = 1'b1;
            end
            else if (res[i] < LO_O)
            begin
                comp_next[i] = W'(LO_O);
                clip_next    = 1'b1;
            end
            else
                comp_next[i] = W'(res[i]);
        end
    end

    assign out_valid = vo_reg;
    assign out_comp  = comp_reg;
    assign out_tir   = tir_o_reg;
    assign out_clip  = clip_o_reg;
endmodule

FILE: rtl/refract_reflect_unit.sv
// Top level of the refract/reflect unit: stream ports, front end, queue, back end.
// Throughput: one word per cycle while m_tready stays high; the square root
// takes one result bit per stage.
// The queue holds up to four words so the front end keeps accepting while the
// output is stalled, until the queue fills. Reset (rst_n low, asynchronous)
// clears all valid flags and queue pointers; data registers are not reset.
module refract_reflect_unit #(
    parameter int COMP_WIDTH = rru_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = rru_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, index_ratio
    input  logic [((7*COMP_WIDTH+7)/8)*8-1:0] s_tdata,
    // mode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_z
    output logic [((3*COMP_WIDTH+7)/8)*8-1:0] m_tdata,
    // total_reflection, clipped
    output logic [1:0]            m_tuser
);
    localparam int W   = COMP_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = F + 2;
    localparam int PLW = 1 + DW + 7 * W;
    localparam int MDW = ((3 * W + 7) / 8) * 8;

    logic signed [W-1:0] s_inc [3], s_nrm [3];
    logic [W-1:0]        s_eta;

    // front end outputs
    logic                f_valid, f_ready, f_mode;
    logic signed [DW-1:0] f_d;
    logic signed [W-1:0] f_inc [3], f_nrm [3];
    logic [W-1:0]        f_eta;

    // queue
    logic [PLW-1:0]      q_in, q_out;
    logic                q_valid, q_ready;
    rru_pkg::fq_status_t q_status;

    // back end inputs
    logic                b_mode;
    logic signed [DW-1:0] b_d;
    logic signed [W-1:0] b_inc [3], b_nrm [3];
    logic [W-1:0]        b_eta;
    logic signed [W-1:0] b_comp [3];
    logic                b_tir, b_clip;

    // unpack the input word
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_inc[i] = s_tdata[i*W +: W];
            s_nrm[i] = s_tdata[(i+3)*W +: W];
        end
        s_eta = s_tdata[6*W +: W];
    end

    rru_front #(.W(W), .F(F)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_inc    (s_inc),
        .in_nrm    (s_nrm),
        .in_eta    (s_eta),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_mode  (f_mode),
        .out_d     (f_d),
        .out_inc   (f_inc),
        .out_nrm   (f_nrm),
        .out_eta   (f_eta)
    );

    // pack the classified word for the queue
    assign q_in = {f_mode, f_eta, f_nrm[2], f_nrm[1], f_nrm[0],
                   f_inc[2], f_inc[1], f_inc[0], f_d};

    rru_fifo #(.WIDTH(PLW), .DEPTH(rru_pkg::FIFO_DEPTH)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out),
        .status    (q_status)
    );

    always_comb
    begin
        b_d = q_out[DW-1:0];
        for (int i = 0; i < 3; i++)
        begin
            b_inc[i] = q_out[DW + i*W +: W];
            b_nrm[i] = q_out[DW + (i+3)*W +: W];
        end
        b_eta  = q_out[DW + 6*W +: W];
        b_mode = q_out[PLW-1];
    end

    rru_back #(.W(W), .F(F)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_mode   (b_mode),
        .in_d      (b_d),
        .in_inc    (b_inc),
        .in_nrm    (b_nrm),
        .in_eta    (b_eta),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_comp  (b_comp),
        .out_tir   (b_tir),
        .out_clip  (b_clip)
    );

    // pack the output word, zero fill to whole bytes
    assign m_tdata = MDW'({b_comp[2], b_comp[1], b_comp[0]});
    assign m_tuser = {b_clip, b_tir};

    // queue can never be full and empty at once
    a_fq_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // a full queue with a finished front word must stall the input
    a_front_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.full && f_valid) |-> !s_tready)
        else $error("input accepted while front end is blocked");

    // a stalled output must hold the queue
    a_back_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !q_ready)
        else $error("queue popped while output stalled");
endmodule
